[rtl/gpio_expander_soft_pwm_core_macros.svh]
// ----------------------------------------------------------------------------
// gpio expander assertion macros
// shared concurrent assertion forms, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef GPIO_EXPANDER_SOFT_PWM_CORE_MACROS_SVH
`define GPIO_EXPANDER_SOFT_PWM_CORE_MACROS_SVH

// same-cycle implication
`define GPESP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPESP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gpesp_pkg.sv]
// ----------------------------------------------------------------------------
// gpesp_pkg
// command codes, decoded operations, queue entry and sequencer state types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpesp_pkg;

  // raw command codes on the input channel
  localparam logic [3:0] CMD_SELECT   = 4'd0;
  localparam logic [3:0] CMD_READ_ALL = 4'd1;
  localparam logic [3:0] CMD_READ_SEL = 4'd2;
  localparam logic [3:0] CMD_DIR      = 4'd3;
  localparam logic [3:0] CMD_DIRS     = 4'd4;
  localparam logic [3:0] CMD_OUT      = 4'd5;
  localparam logic [3:0] CMD_OUTS     = 4'd6;
  localparam logic [3:0] CMD_DUTY     = 4'd7;
  localparam logic [3:0] CMD_PULL     = 4'd8;
  localparam logic [3:0] CMD_PULLS    = 4'd9;
  localparam logic [3:0] CMD_FREQ     = 4'd10;
  localparam logic [3:0] CMD_TICK     = 4'd11;

  // pwm constants
  localparam logic [15:0] DUTY_FULL   = 16'hFFFF;
  localparam logic [15:0] FREQ_RESET  = 16'd50;
  localparam logic [31:0] PWM_SCALE   = 32'd4092;
  localparam logic [7:0]  SEL_NONE    = 8'hFF;

  // command queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // operation after classification; bad pins and unknown codes fold to reject
  typedef enum logic [3:0] {
    OP_SELECT,
    OP_READ_ALL,
    OP_READ_SEL,
    OP_DIR,
    OP_DIRS,
    OP_OUT,
    OP_OUTS,
    OP_DUTY,
    OP_PULL,
    OP_PULLS,
    OP_FREQ,
    OP_TICK,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  pin;
    logic        bit_val;
    logic [15:0] value;
    logic [7:0]  levels;
    logic [31:0] time_us;
  } cmd_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DRAIN,
    ST_RESP
  } back_state_t;

endpackage

`default_nettype wire

[rtl/gpesp_ifs.sv]
// ----------------------------------------------------------------------------
// gpesp channel interfaces
// valid/ready channels for commands in and results out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gpesp_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [7:0]  pin;
  logic [15:0] value;
  logic [7:0]  pin_levels;
  logic [31:0] time_us;

  modport source (output valid, cmd, pin, value, pin_levels, time_us, input ready);
  modport sink   (input valid, cmd, pin, value, pin_levels, time_us, output ready);
endinterface

interface gpesp_res_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] read_data;
  logic [7:0] dir_bits;
  logic [7:0] out_bits;
  logic [7:0] pullup_bits;

  modport source (output valid, status, read_data, dir_bits, out_bits, pullup_bits,
                  input ready);
  modport sink   (input valid, status, read_data, dir_bits, out_bits, pullup_bits,
                  output ready);
endinterface

`default_nettype wire

[rtl/gpesp_front.sv]
// ----------------------------------------------------------------------------
// gpesp_front
// accepts command transactions and classifies them into queue entries
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpesp_front #(
  parameter int NUM_PINS = 8
) (
  gpesp_cmd_if.sink              in_chan,
  input  logic                   q_ready,
  output logic                   q_push,
  output gpesp_pkg::cmd_entry_t  q_entry
);

  logic pin_ok;
  logic single_pin;

  // handshake straight onto the queue
  assign in_chan.ready = q_ready;
  assign q_push        = in_chan.valid && q_ready;

  // decode command, folding bad pins of single-pin commands into reject
  always_comb begin
    pin_ok     = in_chan.pin < 8'(NUM_PINS);
    single_pin = in_chan.cmd inside {gpesp_pkg::CMD_DIR, gpesp_pkg::CMD_OUT,
                                     gpesp_pkg::CMD_DUTY, gpesp_pkg::CMD_PULL,
                                     gpesp_pkg::CMD_FREQ};

    q_entry.pin     = in_chan.pin;
    q_entry.bit_val = |in_chan.value[7:0];
    q_entry.value   = in_chan.value;
    q_entry.levels  = in_chan.pin_levels;
    q_entry.time_us = in_chan.time_us;

    unique case (in_chan.cmd)
      gpesp_pkg::CMD_SELECT:   q_entry.op = gpesp_pkg::OP_SELECT;
      gpesp_pkg::CMD_READ_ALL: q_entry.op = gpesp_pkg::OP_READ_ALL;
      gpesp_pkg::CMD_READ_SEL: q_entry.op = gpesp_pkg::OP_READ_SEL;
      gpesp_pkg::CMD_DIR:      q_entry.op = gpesp_pkg::OP_DIR;
      gpesp_pkg::CMD_DIRS:     q_entry.op = gpesp_pkg::OP_DIRS;
      gpesp_pkg::CMD_OUT:      q_entry.op = gpesp_pkg::OP_OUT;
      gpesp_pkg::CMD_OUTS:     q_entry.op = gpesp_pkg::OP_OUTS;
      gpesp_pkg::CMD_DUTY:     q_entry.op = gpesp_pkg::OP_DUTY;
      gpesp_pkg::CMD_PULL:     q_entry.op = gpesp_pkg::OP_PULL;
      gpesp_pkg::CMD_PULLS:    q_entry.op = gpesp_pkg::OP_PULLS;
      gpesp_pkg::CMD_FREQ:     q_entry.op = gpesp_pkg::OP_FREQ;
      gpesp_pkg::CMD_TICK:     q_entry.op = gpesp_pkg::OP_TICK;
      default:                 q_entry.op = gpesp_pkg::OP_REJECT;
    endcase

    if (single_pin && !pin_ok) begin
      q_entry.op = gpesp_pkg::OP_REJECT;
    end
  end

endmodule

`default_nettype wire

[rtl/gpesp_queue.sv]
// ----------------------------------------------------------------------------
// gpesp_queue
// short fifo of classified commands between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpesp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  gpesp_pkg::cmd_entry_t push_entry,
  output logic                  push_ready,
  input  logic                  pop,
  output logic                  pop_valid,
  output gpesp_pkg::cmd_entry_t pop_entry
);

  gpesp_pkg::cmd_entry_t entries_r [gpesp_pkg::QUEUE_DEPTH];
  logic [gpesp_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [gpesp_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [gpesp_pkg::QPTR_W:0]   count_r, count_nxt;

  assign push_ready = count_r != (gpesp_pkg::QPTR_W + 1)'(gpesp_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_entry  = entries_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[rtl/gpesp_back.sv]
// ----------------------------------------------------------------------------
// gpesp_back
// executes queued commands, holds pin state and walks the pwm tick per pin
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gpio_expander_soft_pwm_core_macros.svh"

module gpesp_back #(
  parameter int NUM_PINS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  gpesp_pkg::cmd_entry_t q_entry,
  output logic                  q_pop,
  gpesp_res_if.source           out_chan
);

  localparam int PIN_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int EXT_W = (NUM_PINS > 8) ? NUM_PINS : 8;
  localparam logic [PIN_W-1:0] LAST_PIN = PIN_W'(NUM_PINS - 1);

  gpesp_pkg::back_state_t state_r, state_nxt;

  logic [NUM_PINS-1:0] dir_r, dir_nxt;
  logic [NUM_PINS-1:0] outb_r, outb_nxt;
  logic [NUM_PINS-1:0] pull_r, pull_nxt;
  logic [NUM_PINS-1:0] pwm_r, pwm_nxt;
  logic [15:0]         duty_r [NUM_PINS];
  logic [15:0]         duty_nxt [NUM_PINS];
  logic [15:0]         freq_r [NUM_PINS];
  logic [15:0]         freq_nxt [NUM_PINS];
  logic [7:0]          sel_r, sel_nxt;

  logic [31:0]         now_r, now_nxt;
  logic [PIN_W-1:0]    idx_r, idx_nxt;

  logic                s1_valid_r, s1_valid_nxt;
  logic [PIN_W-1:0]    s1_idx_r, s1_idx_nxt;
  logic [31:0]         s1_prod_r, s1_prod_nxt;
  logic [15:0]         s1_duty_r, s1_duty_nxt;

  logic                res_valid_r, res_valid_nxt;
  logic                res_status_r, res_status_nxt;
  logic [7:0]          res_data_r, res_data_nxt;
  logic [7:0]          res_dir_r, res_dir_nxt;
  logic [7:0]          res_out_r, res_out_nxt;
  logic [7:0]          res_pull_r, res_pull_nxt;

  logic                slot_free;
  logic                res_load;
  logic [47:0]         mul_full;
  logic [63:0]         scaled_full;
  logic [PIN_W-1:0]    pidx;
  logic                sel_ok;
  logic [EXT_W-1:0]    lv_ext;
  logic [NUM_PINS-1:0] lv_masked;
  logic [NUM_PINS-1:0] val_mask;

  // low eight pins of a per-pin vector, zero padded
  function automatic logic [7:0] low8(input logic [NUM_PINS-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[7:0];
  endfunction

  assign slot_free = !res_valid_r || out_chan.ready;

  // per-pin multiply chain: time x freq now, x 4092 on the next cycle
  assign mul_full    = now_r * freq_r[idx_r];
  assign scaled_full = s1_prod_r * gpesp_pkg::PWM_SCALE;

  // fields shared by several commands
  assign pidx      = q_entry.pin[PIN_W-1:0];
  assign sel_ok    = sel_r < 8'(NUM_PINS);
  assign lv_ext    = EXT_W'(q_entry.levels);
  assign lv_masked = lv_ext[NUM_PINS-1:0];
  assign val_mask  = q_entry.value[NUM_PINS-1:0];

  // sequencer next state, command execution and result loading
  always_comb begin
    state_nxt      = state_r;
    dir_nxt        = dir_r;
    outb_nxt       = outb_r;
    pull_nxt       = pull_r;
    pwm_nxt        = pwm_r;
    duty_nxt       = duty_r;
    freq_nxt       = freq_r;
    sel_nxt        = sel_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    q_pop          = 1'b0;
    res_load       = 1'b0;
    res_status_nxt = 1'b0;
    res_data_nxt   = '0;

    s1_valid_nxt = 1'b0;
    s1_idx_nxt   = idx_r;
    s1_prod_nxt  = mul_full[31:0];
    s1_duty_nxt  = duty_r[idx_r];

    // second pwm stage: compare phase against duty, write the output bit
    if (s1_valid_r) begin
      outb_nxt[s1_idx_r] = scaled_full[31:16] < s1_duty_r;
    end

    unique case (state_r)
      gpesp_pkg::ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (q_entry.op == gpesp_pkg::OP_TICK) begin
            now_nxt   = q_entry.time_us;
            idx_nxt   = '0;
            state_nxt = gpesp_pkg::ST_TICK;
          end else begin
            res_load = 1'b1;
            unique case (q_entry.op)
              gpesp_pkg::OP_SELECT:   sel_nxt = q_entry.pin;
              gpesp_pkg::OP_READ_ALL: res_data_nxt = low8(lv_masked);
              gpesp_pkg::OP_READ_SEL: begin
                if (sel_ok) begin
                  dir_nxt[sel_r[PIN_W-1:0]] = 1'b0;
                  res_data_nxt = {7'd0, (sel_r < 8'd8) ? q_entry.levels[sel_r[2:0]] : 1'b0};
                end else begin
                  res_status_nxt = 1'b1;
                end
              end
              gpesp_pkg::OP_DIR:   dir_nxt[pidx] = q_entry.bit_val;
              gpesp_pkg::OP_DIRS:  dir_nxt = val_mask;
              gpesp_pkg::OP_OUT: begin
                outb_nxt[pidx] = q_entry.bit_val;
                pwm_nxt[pidx]  = 1'b0;
                dir_nxt[pidx]  = 1'b1;
              end
              gpesp_pkg::OP_OUTS:  outb_nxt = val_mask;
              gpesp_pkg::OP_DUTY: begin
                duty_nxt[pidx] = q_entry.value;
                pwm_nxt[pidx]  = 1'b1;
                dir_nxt[pidx]  = 1'b1;
              end
              gpesp_pkg::OP_PULL:  pull_nxt[pidx] = q_entry.bit_val;
              gpesp_pkg::OP_PULLS: pull_nxt = val_mask;
              gpesp_pkg::OP_FREQ:  freq_nxt[pidx] = q_entry.value;
              default:             res_status_nxt = 1'b1;
            endcase
          end
        end
      end
      gpesp_pkg::ST_TICK: begin
        s1_valid_nxt = pwm_r[idx_r] && (duty_r[idx_r] != '0)
                       && (duty_r[idx_r] != gpesp_pkg::DUTY_FULL);
        if (idx_r == LAST_PIN) begin
          state_nxt = gpesp_pkg::ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      gpesp_pkg::ST_DRAIN: begin
        state_nxt = gpesp_pkg::ST_RESP;
      end
      gpesp_pkg::ST_RESP: begin
        if (slot_free) begin
          res_load  = 1'b1;
          state_nxt = gpesp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gpesp_pkg::ST_IDLE;
      end
    endcase

    // output register: drains on a taken transaction, refills on a load
    res_valid_nxt = res_valid_r && !out_chan.ready;
    res_dir_nxt   = res_dir_r;
    res_out_nxt   = res_out_r;
    res_pull_nxt  = res_pull_r;
    if (res_load) begin
      res_valid_nxt = 1'b1;
      res_dir_nxt   = low8(dir_nxt);
      res_out_nxt   = low8(outb_nxt);
      res_pull_nxt  = low8(pull_nxt);
    end else begin
      res_status_nxt = res_status_r;
      res_data_nxt   = res_data_r;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpesp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pin state, tables and control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= '0;
      outb_r      <= '0;
      pull_r      <= '0;
      pwm_r       <= '0;
      sel_r       <= gpesp_pkg::SEL_NONE;
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < NUM_PINS; i++) begin
        duty_r[i] <= '0;
        freq_r[i] <= gpesp_pkg::FREQ_RESET;
      end
    end else begin
      dir_r       <= dir_nxt;
      outb_r      <= outb_nxt;
      pull_r      <= pull_nxt;
      pwm_r       <= pwm_nxt;
      sel_r       <= sel_nxt;
      s1_valid_r  <= s1_valid_nxt;
      res_valid_r <= res_valid_nxt;
      duty_r      <= duty_nxt;
      freq_r      <= freq_nxt;
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    idx_r        <= idx_nxt;
    s1_idx_r     <= s1_idx_nxt;
    s1_prod_r    <= s1_prod_nxt;
    s1_duty_r    <= s1_duty_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_dir_r    <= res_dir_nxt;
    res_out_r    <= res_out_nxt;
    res_pull_r   <= res_pull_nxt;
  end

  assign out_chan.valid       = res_valid_r;
  assign out_chan.status      = res_status_r;
  assign out_chan.read_data   = res_data_r;
  assign out_chan.dir_bits    = res_dir_r;
  assign out_chan.out_bits    = res_out_r;
  assign out_chan.pullup_bits = res_pull_r;

  // checks
  `GPESP_ASSERT_SAME(a_pop_idle, q_pop, state_r == gpesp_pkg::ST_IDLE, "pop outside idle")
  `GPESP_ASSERT_SAME(a_no_overwrite, res_load, slot_free, "result overwritten before taken")
  `GPESP_ASSERT_SAME(a_s1_in_tick, s1_valid_r,
    (state_r == gpesp_pkg::ST_TICK) || (state_r == gpesp_pkg::ST_DRAIN), "pwm stage active outside tick")
  `GPESP_ASSERT_NEXT(a_drain_resp, state_r == gpesp_pkg::ST_DRAIN,
    state_r == gpesp_pkg::ST_RESP, "drain not followed by response")

endmodule

`default_nettype wire

[rtl/gpio_expander_soft_pwm_core.sv]
// ----------------------------------------------------------------------------
// gpio_expander_soft_pwm_core
// command-driven gpio expander with per-pin software pwm
// ----------------------------------------------------------------------------
// usage:
//   in_chan carries one command per transaction (cmd, pin, value, sampled
//   pin_levels, time_us); out_chan returns exactly one result per command
//   with status, read data and the direction, output and pullup bits as
//   they stand after that command.
//   commands pass through a two-entry queue; the back end executes a plain
//   command as it pops it and loads its result into the output register;
//   plain commands sustain one per cycle while the receiver keeps ready high.
//   a tick walks the pins through one shared two-stage multiply chain, one
//   pin per cycle, then passes through the drain and response states in the
//   back end before its result is loaded.
//   the result sits in an output register; while the receiver stalls, the
//   queue keeps taking commands until it is full, then in_chan.ready drops.
//   reset (synchronous, active low) clears all pin state, sets every
//   frequency to 50 and leaves no pin selected; the queue and output
//   register come up empty.
`timescale 1ns / 1ps
`default_nettype none

module gpio_expander_soft_pwm_core #(
  parameter int NUM_PINS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  gpesp_cmd_if.sink   in_chan,
  gpesp_res_if.source out_chan
);

  logic                  q_push;
  logic                  q_ready;
  logic                  q_pop;
  logic                  q_valid;
  gpesp_pkg::cmd_entry_t push_entry;
  gpesp_pkg::cmd_entry_t head_entry;

  // front: accept and classify
  gpesp_front #(
    .NUM_PINS (NUM_PINS)
  ) u_front (
    .in_chan (in_chan),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  // queue between front and back
  gpesp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (head_entry)
  );

  // back: execute and answer
  gpesp_back #(
    .NUM_PINS (NUM_PINS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (head_entry),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

[sim/gpio_expander_soft_pwm_core_tb.sv]
// ----------------------------------------------------------------------------
// gpio_expander_soft_pwm_core_tb
// self-checking bench for the command-driven gpio expander with software pwm:
// a queue-fed driver pushes commands, a shadow model of the pin registers
// predicts each result and a monitor checks every field of every result
// under phases of sender idling and receiver stalling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpio_expander_soft_pwm_core_tb;
  import gpesp_pkg::*;

  localparam int NUM_PINS     = 8;
  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 32;

  typedef enum logic [1:0] {
    MODE_FLAT,
    MODE_SEND_IDLE,
    MODE_RECV_STALL,
    MODE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [3:0]  cmd;
    logic [7:0]  pin;
    logic [15:0] value;
    logic [7:0]  levels;
    logic [31:0] time_us;
    idle_mode_t  mode;
  } gpio_cmd_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_data;
    logic [7:0] dir_bits;
    logic [7:0] out_bits;
    logic [7:0] pullup_bits;
  } gpio_result_t;

  logic clk = 1'b0;
  logic rst_n;

  gpesp_cmd_if in_if ();
  gpesp_res_if out_if ();

  gpio_expander_soft_pwm_core #(
    .NUM_PINS (NUM_PINS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source)
  );

  // clock
  always #1 clk = ~clk;

  // shadow copy of the pin registers
  logic [NUM_PINS-1:0] pin_dir;
  logic [NUM_PINS-1:0] pin_out;
  logic [NUM_PINS-1:0] pin_pull;
  logic [NUM_PINS-1:0] pwm_en;
  logic [15:0]         duty_tab [NUM_PINS];
  logic [15:0]         freq_tab [NUM_PINS];
  logic [7:0]          sel_pin;

  gpio_cmd_t    pending_cmds [$];
  gpio_result_t pin_results  [$];
  gpio_cmd_t    cur_cmd;
  idle_mode_t   idle_mode = MODE_FLAT;

  int n_items    = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_ticks    = 0;
  int n_rejects  = 0;
  int n_reads    = 0;
  int quiet_cycles = 0;

  // shadow model reset
  task automatic clear_pin_model();
    pin_dir  = '0;
    pin_out  = '0;
    pin_pull = '0;
    pwm_en   = '0;
    for (int i = 0; i < NUM_PINS; i++) begin
      duty_tab[i] = 16'd0;
      freq_tab[i] = FREQ_RESET;
    end
    sel_pin = SEL_NONE;
  endtask

  // apply one command to the shadow registers and work out its result
  function automatic gpio_result_t apply_command(input gpio_cmd_t c);
    gpio_result_t        r;
    logic                bit_on;
    logic [NUM_PINS-1:0] mask;
    logic                pin_ok;
    logic [31:0]         prod;
    r      = '0;
    bit_on = (c.value[7:0] != 8'd0);
    mask   = c.value[NUM_PINS-1:0];
    pin_ok = (c.pin < NUM_PINS);
    case (c.cmd)
      CMD_SELECT: sel_pin = c.pin;
      CMD_READ_ALL: r.read_data = c.levels;
      CMD_READ_SEL: begin
        if (sel_pin < NUM_PINS) begin
          pin_dir[sel_pin] = 1'b0;
          r.read_data      = {7'd0, c.levels[sel_pin]};
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_DIR: begin
        if (pin_ok) pin_dir[c.pin] = bit_on;
        else r.status = 1'b1;
      end
      CMD_DIRS: pin_dir = mask;
      CMD_OUT: begin
        if (pin_ok) begin
          pin_out[c.pin] = bit_on;
          pwm_en[c.pin]  = 1'b0;
          pin_dir[c.pin] = 1'b1;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_OUTS: pin_out = mask;
      CMD_DUTY: begin
        if (pin_ok) begin
          duty_tab[c.pin] = c.value;
          pwm_en[c.pin]   = 1'b1;
          pin_dir[c.pin]  = 1'b1;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_PULL: begin
        if (pin_ok) pin_pull[c.pin] = bit_on;
        else r.status = 1'b1;
      end
      CMD_PULLS: pin_pull = mask;
      CMD_FREQ: begin
        if (pin_ok) freq_tab[c.pin] = c.value;
        else r.status = 1'b1;
      end
      CMD_TICK: begin
        // software pwm: phase is the top half of the wrapping product
        for (int i = 0; i < NUM_PINS; i++) begin
          if (pwm_en[i] && duty_tab[i] != 16'd0 && duty_tab[i] != DUTY_FULL) begin
            prod       = c.time_us * {16'd0, freq_tab[i]} * PWM_SCALE;
            pin_out[i] = (prod[31:16] < duty_tab[i]);
          end
        end
      end
      default: r.status = 1'b1;
    endcase
    r.dir_bits    = pin_dir;
    r.out_bits    = pin_out;
    r.pullup_bits = pin_pull;
    return r;
  endfunction

  task automatic add_cmd(input logic [3:0] cmd, input logic [7:0] pin,
                         input logic [15:0] value, input logic [7:0] levels,
                         input logic [31:0] time_us, input idle_mode_t mode);
    gpio_cmd_t c;
    c.cmd     = cmd;
    c.pin     = pin;
    c.value   = value;
    c.levels  = levels;
    c.time_us = time_us;
    c.mode    = mode;
    pending_cmds.push_back(c);
    n_items++;
  endtask

  // directed commands: field extremes, every command and the corner cases
  task automatic add_directed_cmds();
    add_cmd(CMD_READ_ALL, 8'd0,   16'h0000, 8'hA5, 32'd0, MODE_FLAT);
    // read with no pin selected
    add_cmd(CMD_READ_SEL, 8'd0,   16'h0000, 8'hFF, 32'd0, MODE_FLAT);
    add_cmd(CMD_SELECT,   8'd7,   16'h0000, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_READ_SEL, 8'd0,   16'h0000, 8'h80, 32'd0, MODE_FLAT);
    // select out of range, then read it
    add_cmd(CMD_SELECT,   8'd200, 16'h0000, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_READ_SEL, 8'd0,   16'h0000, 8'hFF, 32'd0, MODE_FLAT);
    // bad pins on single-pin commands
    add_cmd(CMD_DIR,      8'd8,   16'h0001, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_OUT,      8'd255, 16'hFFFF, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_DIRS,     8'd0,   16'hFFFF, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_OUTS,     8'd0,   16'h5A5A, 8'h00, 32'd0, MODE_FLAT);
    // bit value taken from the low byte only
    add_cmd(CMD_OUT,      8'd0,   16'h0100, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_OUT,      8'd7,   16'h00FF, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_DUTY,     8'd3,   16'h8000, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_DUTY,     8'd4,   16'h0000, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_DUTY,     8'd5,   DUTY_FULL, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_FREQ,     8'd3,   16'hFFFF, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_PULL,     8'd2,   16'h0001, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_PULLS,    8'd0,   16'hFFFF, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_TICK,     8'd0,   16'h0000, 8'h00, 32'hFFFF_FFFF, MODE_FLAT);
    add_cmd(CMD_TICK,     8'd0,   16'h0000, 8'h00, 32'd0, MODE_FLAT);
    // zero frequency keeps the phase at zero
    add_cmd(CMD_DUTY,     8'd0,   16'h0001, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_FREQ,     8'd0,   16'h0000, 8'h00, 32'd0, MODE_FLAT);
    add_cmd(CMD_TICK,     8'd255, 16'hFFFF, 8'hFF, 32'h1234_5678, MODE_FLAT);
    // unknown command codes
    for (int k = 12; k < 16; k++) add_cmd(4'(k), 8'(k - 12), 16'hFFFF, 8'hFF, 32'd0, MODE_FLAT);
  endtask

  // random commands weighted towards pwm set-up and ticks
  task automatic add_random_cmds();
    idle_mode_t  mode;
    logic [3:0]  cmd;
    logic [7:0]  pin;
    logic [15:0] value;
    int          roll;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mode = idle_mode_t'((n * 4) / RANDOM_ITEMS);
      roll = $urandom_range(99);
      if      (roll < 6)  cmd = CMD_SELECT;
      else if (roll < 11) cmd = CMD_READ_ALL;
      else if (roll < 17) cmd = CMD_READ_SEL;
      else if (roll < 23) cmd = CMD_DIR;
      else if (roll < 27) cmd = CMD_DIRS;
      else if (roll < 34) cmd = CMD_OUT;
      else if (roll < 38) cmd = CMD_OUTS;
      else if (roll < 52) cmd = CMD_DUTY;
      else if (roll < 58) cmd = CMD_PULL;
      else if (roll < 62) cmd = CMD_PULLS;
      else if (roll < 72) cmd = CMD_FREQ;
      else if (roll < 96) cmd = CMD_TICK;
      else                cmd = 4'($urandom_range(15, 12));
      if ($urandom_range(99) < 85) pin = 8'($urandom_range(NUM_PINS - 1));
      else                         pin = 8'($urandom_range(255));
      value = 16'($urandom);
      if (cmd == CMD_DUTY) begin
        roll = $urandom_range(9);
        if (roll == 0)      value = 16'h0000;
        else if (roll == 1) value = DUTY_FULL;
      end else if (cmd == CMD_FREQ && $urandom_range(99) < 60) begin
        value = 16'($urandom_range(200));
      end
      add_cmd(cmd, pin, value, 8'($urandom), $urandom, mode);
    end
  endtask

  function automatic logic sender_idles(input idle_mode_t m);
    case (m)
      MODE_SEND_IDLE: return ($urandom_range(99) < 65);
      MODE_BOTH:      return ($urandom_range(99) < 19);
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls(input idle_mode_t m);
    case (m)
      MODE_RECV_STALL: return ($urandom_range(99) < 65);
      MODE_BOTH:       return ($urandom_range(99) < 19);
      default:         return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on result %0d: %s got 0x%0h expected 0x%0h",
             $realtime, n_checked, what, got, want);
    n_errors++;
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pin_results.push_back(apply_command(cur_cmd));
        n_accepted++;
        if (cur_cmd.cmd == CMD_TICK) n_ticks++;
        if (cur_cmd.cmd == CMD_READ_ALL || cur_cmd.cmd == CMD_READ_SEL) n_reads++;
      end
      // present the next command once the last one has gone
      if (!in_if.valid || in_if.ready) begin
        if (pending_cmds.size() != 0 && !sender_idles(pending_cmds[0].mode)) begin
          cur_cmd          = pending_cmds.pop_front();
          idle_mode       <= cur_cmd.mode;
          in_if.cmd       <= cur_cmd.cmd;
          in_if.pin       <= cur_cmd.pin;
          in_if.value     <= cur_cmd.value;
          in_if.pin_levels <= cur_cmd.levels;
          in_if.time_us   <= cur_cmd.time_us;
          in_if.valid     <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pin_results.size() == 0) begin
          report_mismatch("unexpected transaction, status", 32'(out_if.status), 32'd0);
        end else begin
          gpio_result_t want;
          want = pin_results.pop_front();
          if (want.status) n_rejects++;
          if (out_if.status !== want.status)
            report_mismatch("status", 32'(out_if.status), 32'(want.status));
          if (out_if.read_data !== want.read_data)
            report_mismatch("read_data", 32'(out_if.read_data), 32'(want.read_data));
          if (out_if.dir_bits !== want.dir_bits)
            report_mismatch("dir_bits", 32'(out_if.dir_bits), 32'(want.dir_bits));
          if (out_if.out_bits !== want.out_bits)
            report_mismatch("out_bits", 32'(out_if.out_bits), 32'(want.out_bits));
          if (out_if.pullup_bits !== want.pullup_bits)
            report_mismatch("pullup_bits", 32'(out_if.pullup_bits), 32'(want.pullup_bits));
        end
        n_checked++;
      end
      out_if.ready <= !receiver_stalls(idle_mode);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n && !(in_if.valid && in_if.ready) && !(out_if.valid && out_if.ready))
      quiet_cycles <= quiet_cycles + 1;
    else
      quiet_cycles <= 0;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[%0t] timeout: no transaction for %0d cycles, %0d results outstanding",
             $realtime, QUIET_LIMIT, pin_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // reset, stimulus and end of run
  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_SELECT;
    in_if.pin        = 8'd0;
    in_if.value      = 16'd0;
    in_if.pin_levels = 8'd0;
    in_if.time_us    = 32'd0;
    out_if.ready     = 1'b0;
    clear_pin_model();
    add_directed_cmds();
    add_random_cmds();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (n_accepted < n_items) @(posedge clk);
    while (pin_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d commands (%0d ticks, %0d reads, %0d rejected), %0d results checked",
             n_accepted, n_ticks, n_reads, n_rejects, n_checked);
    $display("phases: no idling, sender idling, receiver stalling, both; %0d mismatches",
             n_errors);
    if (n_errors == 0 && pin_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
